@@ rtl/core/lr_pkg.sv @@
// lr_pkg: shared constants for the line rasterizer core
// operation codes, configuration register indexes and reset values
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package lr_pkg;

    // coordinate width default, legal range 8 to 24
    localparam int COORD_BITS_DEF = 16;

    // queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // operation codes
    localparam logic OP_START = 1'b0;
    localparam logic OP_STEP  = 1'b1;

    // configuration register file
    localparam int CFG_DATA_W   = 15;
    localparam int CFG_INDEX_W  = 1;
    localparam logic [CFG_INDEX_W-1:0] CFG_SURFACE_WIDTH  = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SURFACE_HEIGHT = 1'b1;

    localparam logic [CFG_DATA_W-1:0] SURFACE_WIDTH_RST  = 15'd640;
    localparam logic [CFG_DATA_W-1:0] SURFACE_HEIGHT_RST = 15'd480;

    localparam int COLOR_W = 32;

endpackage

`default_nettype wire

@@ rtl/core/lr_front.sv @@
// lr_front: accepts input beats and classifies them for the back end
// orders endpoints by y and forms |dx|, dy and the x direction; uses lr_pkg
`timescale 1ns / 1ps
`default_nettype none

module lr_front #(
    parameter int COORD_BITS = lr_pkg::COORD_BITS_DEF,
    localparam int ENTRY_W = 4 * COORD_BITS + 2 + lr_pkg::COLOR_W
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       s_valid,
    output logic                            s_ready,
    input  wire logic                       s_op,
    input  wire logic signed [COORD_BITS-1:0] s_x_start,
    input  wire logic signed [COORD_BITS-1:0] s_y_start,
    input  wire logic signed [COORD_BITS-1:0] s_x_end,
    input  wire logic signed [COORD_BITS-1:0] s_y_end,
    input  wire logic [lr_pkg::COLOR_W-1:0] s_line_color,
    output logic                            push,
    output logic [ENTRY_W-1:0]              push_entry,
    input  wire logic                       queue_full
);

    localparam int C = COORD_BITS;

    logic                   swap;
    logic signed [C-1:0]    xa, ya, xb, yb;
    logic signed [C:0]      dx;
    logic [C-1:0]           dy;
    logic [C:0]             dx_neg;
    logic [C-1:0]           adx;
    logic                   xneg;
    logic                   unused_clk;

    assign unused_clk = aclk ^ aresetn;

    assign s_ready = !queue_full;
    assign push    = s_valid && !queue_full;

    always_comb begin
        swap   = s_y_end < s_y_start;
        xa     = swap ? s_x_end   : s_x_start;
        ya     = swap ? s_y_end   : s_y_start;
        xb     = swap ? s_x_start : s_x_end;
        yb     = swap ? s_y_start : s_y_end;
        dx     = {xb[C-1], xb} - {xa[C-1], xa};
        dy     = C'({yb[C-1], yb} - {ya[C-1], ya});
        dx_neg = -dx;
        // direction is negative when dx is not positive, vertical lines included
        xneg   = dx[C] || (dx == '0);
        adx    = dx[C] ? dx_neg[C-1:0] : dx[C-1:0];
    end

    assign push_entry = {s_op, xa, ya, adx, dy, xneg, s_line_color};

endmodule

`default_nettype wire

@@ rtl/core/lr_queue.sv @@
// lr_queue: short fifo between the classifying front and the stepping back end
// register array with head and tail pointers; uses lr_pkg
`timescale 1ns / 1ps
`default_nettype none

module lr_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = lr_pkg::QUEUE_DEPTH
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] push_entry,
    output logic                  full,
    input  wire logic             pop,
    output logic                  not_empty,
    output logic [WIDTH-1:0]      head_entry
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_push, do_pop;

    assign full       = count_reg == CW'(DEPTH);
    assign not_empty  = count_reg != '0;
    assign do_push    = push && !full;
    assign do_pop     = pop && not_empty;
    assign head_entry = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/lr_back.sv @@
// lr_back: line state, bresenham stepping, clipping and the output register
// holds the surface size registers; uses lr_pkg
`timescale 1ns / 1ps
`default_nettype none

module lr_back #(
    parameter int COORD_BITS = lr_pkg::COORD_BITS_DEF,
    localparam int ENTRY_W = 4 * COORD_BITS + 2 + lr_pkg::COLOR_W
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_we,
    input  wire logic [lr_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [lr_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire logic                          not_empty,
    input  wire logic [ENTRY_W-1:0]            head_entry,
    output logic                               pop,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic signed [COORD_BITS-1:0]       m_pixel_x,
    output logic signed [COORD_BITS-1:0]       m_pixel_y,
    output logic [lr_pkg::COLOR_W-1:0]         m_pixel_color,
    output logic                               m_write_enable,
    output logic                               m_last
);

    localparam int C   = COORD_BITS;
    localparam int IW  = C + 3;
    localparam int EW  = C + 4;
    localparam int SW  = C + 1;
    localparam int CFW = lr_pkg::CFG_DATA_W;
    localparam int KW  = ((C > CFW) ? C : CFW) + 1;

    // surface size
    logic [CFW-1:0] width_reg, height_reg;

    // line state
    logic [C-1:0]  cur_x_reg, cur_x_next;
    logic [C-1:0]  cur_y_reg, cur_y_next;
    logic [EW-1:0] err_reg, err_next;
    logic [IW-1:0] inc_s_reg, inc_s_next;
    logic [IW-1:0] inc_d_reg, inc_d_next;
    logic [SW-1:0] steps_reg, steps_next;
    logic          xmaj_reg, xmaj_next;
    logic          xneg_reg, xneg_next;
    logic [lr_pkg::COLOR_W-1:0] color_reg, color_next;
    logic          active_reg, active_next;

    // output register
    logic          out_valid_reg, out_valid_next;
    logic [C-1:0]  out_x_reg, out_y_reg;
    logic [lr_pkg::COLOR_W-1:0] out_color_reg;
    logic          out_we_reg, out_last_reg;

    // head entry fields
    logic          e_op;
    logic [C-1:0]  e_xa, e_ya, e_adx, e_dy;
    logic          e_xneg;
    logic [lr_pkg::COLOR_W-1:0] e_color;

    logic          xmaj_c, take;
    logic [C-1:0]  maj, mnr;
    logic [IW-1:0] add;
    logic          we_c, last_c;
    logic          in_surface;

    assign {e_op, e_xa, e_ya, e_adx, e_dy, e_xneg, e_color} = head_entry;

    assign pop = not_empty && (!out_valid_reg || m_ready);

    always_comb begin
        cur_x_next  = cur_x_reg;
        cur_y_next  = cur_y_reg;
        err_next    = err_reg;
        inc_s_next  = inc_s_reg;
        inc_d_next  = inc_d_reg;
        steps_next  = steps_reg;
        xmaj_next   = xmaj_reg;
        xneg_next   = xneg_reg;
        color_next  = color_reg;
        active_next = active_reg;
        we_c        = 1'b0;
        last_c      = 1'b1;

        xmaj_c = e_adx > e_dy;
        maj    = xmaj_c ? e_adx : e_dy;
        mnr    = xmaj_c ? e_dy  : e_adx;

        // x-major steps on error >= 0, y-major only on error > 0
        take = !err_reg[EW-1] && (xmaj_reg || (err_reg != '0));
        add  = take ? inc_d_reg : inc_s_reg;

        if (e_op == lr_pkg::OP_START) begin
            cur_x_next  = e_xa;
            cur_y_next  = e_ya;
            inc_s_next  = {2'b00, mnr, 1'b0};
            inc_d_next  = {2'b00, mnr, 1'b0} - {2'b00, maj, 1'b0};
            err_next    = {3'b000, mnr, 1'b0} - {4'b0000, maj};
            steps_next  = {1'b0, maj};
            xmaj_next   = xmaj_c;
            xneg_next   = e_xneg;
            color_next  = e_color;
            active_next = maj != '0;
            we_c        = 1'b1;
            last_c      = maj == '0;
        end else if (active_reg) begin
            err_next = err_reg + {add[IW-1], add};
            if (xmaj_reg || take) begin
                cur_x_next = cur_x_reg + {{(C-1){xneg_reg}}, 1'b1};
            end
            if (!xmaj_reg || take) begin
                cur_y_next = cur_y_reg + 1'b1;
            end
            steps_next  = steps_reg - 1'b1;
            active_next = steps_next != '0;
            we_c        = 1'b1;
            last_c      = steps_next == '0;
        end

        in_surface = !cur_x_next[C-1] && !cur_y_next[C-1]
            && ({{(KW-C){1'b0}}, cur_x_next} < {{(KW-CFW){1'b0}}, width_reg})
            && ({{(KW-C){1'b0}}, cur_y_next} < {{(KW-CFW){1'b0}}, height_reg});

        out_valid_next = pop ? 1'b1 : (m_ready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= lr_pkg::SURFACE_WIDTH_RST;
            height_reg <= lr_pkg::SURFACE_HEIGHT_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                lr_pkg::CFG_SURFACE_WIDTH:  width_reg  <= cfg_data;
                lr_pkg::CFG_SURFACE_HEIGHT: height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_x_reg     <= '0;
            cur_y_reg     <= '0;
            err_reg       <= '0;
            inc_s_reg     <= '0;
            inc_d_reg     <= '0;
            steps_reg     <= '0;
            xmaj_reg      <= 1'b0;
            xneg_reg      <= 1'b0;
            color_reg     <= '0;
            active_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
            if (pop) begin
                cur_x_reg  <= cur_x_next;
                cur_y_reg  <= cur_y_next;
                err_reg    <= err_next;
                inc_s_reg  <= inc_s_next;
                inc_d_reg  <= inc_d_next;
                steps_reg  <= steps_next;
                xmaj_reg   <= xmaj_next;
                xneg_reg   <= xneg_next;
                color_reg  <= color_next;
                active_reg <= active_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            out_x_reg     <= cur_x_next;
            out_y_reg     <= cur_y_next;
            out_color_reg <= color_next;
            out_we_reg    <= we_c && in_surface;
            out_last_reg  <= last_c;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_pixel_x      = out_x_reg;
    assign m_pixel_y      = out_y_reg;
    assign m_pixel_color  = out_color_reg;
    assign m_write_enable = out_we_reg;
    assign m_last         = out_last_reg;

endmodule

`default_nettype wire

@@ rtl/core/line_rasterizer_core.sv @@
// line_rasterizer_core: bresenham line rasterizer with surface clipping
// top level joining lr_front, lr_queue and lr_back; uses lr_pkg
//
// usage:
//   input channel (s_valid / s_ready): op 0 starts a line from the two
//   endpoints and color, op 1 advances one pixel. every input beat gives
//   exactly one output beat on the m_ channel, in order.
//   a start beat returns the first pixel; each step beat returns the next.
//   write_enable is low for pixels outside the surface and for steps taken
//   while no line is active; last marks the final pixel (and idle steps).
//   config port: cfg_we with cfg_index 0 (surface width) or 1 (surface
//   height); write only while the block is idle.
//   path: an accepted beat enters a two-entry queue; the back end steps
//   it combinationally when it pops it and registers the pixel for m_.
//   throughput: one beat per cycle while m_ready stays high, set by the
//   combinational step of the back end and its output register.
//   stall: when m_ready is low the output register holds; the queue
//   fills up to its two entries before s_ready drops.
//   reset (aresetn low, synchronous): queue empty, no line active, surface
//   640 by 480.
`timescale 1ns / 1ps
`default_nettype none

module line_rasterizer_core #(
    parameter int COORD_BITS = lr_pkg::COORD_BITS_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_we,
    input  wire logic [lr_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [lr_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic                          s_op,
    input  wire logic signed [COORD_BITS-1:0]  s_x_start,
    input  wire logic signed [COORD_BITS-1:0]  s_y_start,
    input  wire logic signed [COORD_BITS-1:0]  s_x_end,
    input  wire logic signed [COORD_BITS-1:0]  s_y_end,
    input  wire logic [lr_pkg::COLOR_W-1:0]    s_line_color,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic signed [COORD_BITS-1:0]       m_pixel_x,
    output logic signed [COORD_BITS-1:0]       m_pixel_y,
    output logic [lr_pkg::COLOR_W-1:0]         m_pixel_color,
    output logic                               m_write_enable,
    output logic                               m_last
);

    localparam int ENTRY_W = 4 * COORD_BITS + 2 + lr_pkg::COLOR_W;

    logic               push, pop, queue_full, not_empty;
    logic [ENTRY_W-1:0] push_entry, head_entry;

    lr_front #(
        .COORD_BITS(COORD_BITS)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_op        (s_op),
        .s_x_start   (s_x_start),
        .s_y_start   (s_y_start),
        .s_x_end     (s_x_end),
        .s_y_end     (s_y_end),
        .s_line_color(s_line_color),
        .push        (push),
        .push_entry  (push_entry),
        .queue_full  (queue_full)
    );

    lr_queue #(
        .WIDTH(ENTRY_W),
        .DEPTH(lr_pkg::QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_entry(push_entry),
        .full      (queue_full),
        .pop       (pop),
        .not_empty (not_empty),
        .head_entry(head_entry)
    );

    lr_back #(
        .COORD_BITS(COORD_BITS)
    ) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .not_empty     (not_empty),
        .head_entry    (head_entry),
        .pop           (pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_pixel_x     (m_pixel_x),
        .m_pixel_y     (m_pixel_y),
        .m_pixel_color (m_pixel_color),
        .m_write_enable(m_write_enable),
        .m_last        (m_last)
    );

endmodule

`default_nettype wire

@@ tb/tb_top.sv @@
// tb_top: self-checking testbench for line_rasterizer_core
// drives start and step beats, predicts every pixel and checks it against the m_ channel
// depends on lr_pkg and line_rasterizer_core
`timescale 1ns / 1ps

module tb_top;
    import lr_pkg::*;

    localparam int CW = COORD_BITS_DEF;
    localparam int COORD_MAX = 2 ** (CW - 1) - 1;
    localparam int COORD_MIN = -(2 ** (CW - 1));
    localparam int CYCLE_LIMIT = 400000;
    localparam int TAIL_CYCLES = 16;
    localparam int LONG_HOLD = 300;

    typedef struct {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic [COLOR_W-1:0]   color;
        logic                 we;
        logic                 last;
    } pixel_t;

    logic                   aclk;
    logic                   aresetn;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   s_valid;
    logic                   s_ready;
    logic                   s_op;
    logic signed [CW-1:0]   s_x_start;
    logic signed [CW-1:0]   s_y_start;
    logic signed [CW-1:0]   s_x_end;
    logic signed [CW-1:0]   s_y_end;
    logic [COLOR_W-1:0]     s_line_color;
    logic                   m_valid;
    logic                   m_ready;
    logic signed [CW-1:0]   m_pixel_x;
    logic signed [CW-1:0]   m_pixel_y;
    logic [COLOR_W-1:0]     m_pixel_color;
    logic                   m_write_enable;
    logic                   m_last;

    line_rasterizer_core #(.COORD_BITS(CW)) uut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_op           (s_op),
        .s_x_start      (s_x_start),
        .s_y_start      (s_y_start),
        .s_x_end        (s_x_end),
        .s_y_end        (s_y_end),
        .s_line_color   (s_line_color),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_pixel_x      (m_pixel_x),
        .m_pixel_y      (m_pixel_y),
        .m_pixel_color  (m_pixel_color),
        .m_write_enable (m_write_enable),
        .m_last         (m_last)
    );

    // predicted rasterizer state
    logic [CFG_DATA_W-1:0]  surf_w;
    logic [CFG_DATA_W-1:0]  surf_h;
    logic signed [CW-1:0]   pos_x;
    logic signed [CW-1:0]   pos_y;
    logic signed [CW+3:0]   err_acc;
    logic signed [CW+2:0]   step_straight;
    logic signed [CW+2:0]   step_diag;
    logic [CW:0]            pixels_left;
    logic                   is_x_major;
    logic                   dir_negative;
    logic [COLOR_W-1:0]     line_rgba;
    logic                   line_busy;

    pixel_t pending_pixels[$];

    int fail_count = 0;
    int beats_sent = 0;
    int pixels_checked = 0;
    int lines_started = 0;
    int settings_tried = 1;
    int cycle_count = 0;
    int hold_req = 0;
    int sink_stall_left = 0;
    bit src_idle_en = 1'b0;
    bit sink_idle_en = 1'b0;
    bit allow_idle = 1'b1;

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    function automatic void reset_model();
        surf_w = SURFACE_WIDTH_RST;
        surf_h = SURFACE_HEIGHT_RST;
        pos_x = '0;
        pos_y = '0;
        err_acc = '0;
        step_straight = '0;
        step_diag = '0;
        pixels_left = '0;
        is_x_major = 1'b0;
        dir_negative = 1'b0;
        line_rgba = '0;
        line_busy = 1'b0;
    endfunction

    function automatic pixel_t make_pixel(logic we, logic last_px);
        pixel_t px;
        logic in_surface;
        in_surface = int'(pos_x) >= 0 && int'(pos_x) < int'(surf_w) &&
                     int'(pos_y) >= 0 && int'(pos_y) < int'(surf_h);
        px.x = pos_x;
        px.y = pos_y;
        px.color = line_rgba;
        px.we = we && in_surface;
        px.last = last_px;
        return px;
    endfunction

    function automatic pixel_t rasterize(logic op, logic signed [CW-1:0] xs,
                                         logic signed [CW-1:0] ys, logic signed [CW-1:0] xe,
                                         logic signed [CW-1:0] ye, logic [COLOR_W-1:0] color);
        int xa, ya, xb, yb, dx, dy;
        if (op == OP_START) begin
            xa = xs;
            ya = ys;
            xb = xe;
            yb = ye;
            // walk with y increasing
            if (yb < ya) begin
                xa = xe;
                ya = ye;
                xb = xs;
                yb = ys;
            end
            dx = xb - xa;
            dy = yb - ya;
            dir_negative = !(dx > 0);
            if (dx < 0) dx = -dx;
            is_x_major = dx > dy;
            if (is_x_major) begin
                step_straight = 2 * dy;
                step_diag = 2 * dy - 2 * dx;
                err_acc = 2 * dy - dx;
                pixels_left = dx;
            end else begin
                step_straight = 2 * dx;
                step_diag = 2 * (dx - dy);
                err_acc = 2 * dx - dy;
                pixels_left = dy;
            end
            pos_x = xa;
            pos_y = ya;
            line_rgba = color;
            line_busy = pixels_left != 0;
            return make_pixel(1'b1, !line_busy);
        end
        if (!line_busy) return make_pixel(1'b0, 1'b1);
        if (is_x_major) begin
            if (err_acc >= 0) begin
                pos_y = pos_y + 1;
                err_acc = err_acc + step_diag;
            end else begin
                err_acc = err_acc + step_straight;
            end
            pos_x = dir_negative ? pos_x - 1 : pos_x + 1;
        end else begin
            // y-major steps x only on a strictly positive error
            if (err_acc > 0) begin
                pos_x = dir_negative ? pos_x - 1 : pos_x + 1;
                err_acc = err_acc + step_diag;
            end else begin
                err_acc = err_acc + step_straight;
            end
            pos_y = pos_y + 1;
        end
        pixels_left = pixels_left - 1;
        line_busy = pixels_left != 0;
        return make_pixel(1'b1, !line_busy);
    endfunction

    function automatic logic signed [CW-1:0] near_coord(int extent);
        int hi, v;
        hi = (extent + 20 > COORD_MAX) ? COORD_MAX : extent + 20;
        v = int'($urandom_range(0, hi + 20)) - 20;
        return v[CW-1:0];
    endfunction

    function automatic logic signed [CW-1:0] offset_coord(logic signed [CW-1:0] base, int span);
        int d, e;
        d = int'($urandom_range(0, 2 * span)) - span;
        e = int'(base) + d;
        if (e > COORD_MAX || e < COORD_MIN) e = int'(base) - d;
        return e[CW-1:0];
    endfunction

    // pixel checker
    always @(posedge aclk) begin
        pixel_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_pixels.size() == 0) begin
                $error("pixel beat with nothing expected: x %0d y %0d", m_pixel_x, m_pixel_y);
                fail_count++;
            end else begin
                want = pending_pixels.pop_front();
                pixels_checked++;
                if (m_pixel_x !== want.x) begin
                    $error("pixel_x: expected %0d, got %0d", want.x, m_pixel_x);
                    fail_count++;
                end
                if (m_pixel_y !== want.y) begin
                    $error("pixel_y: expected %0d, got %0d", want.y, m_pixel_y);
                    fail_count++;
                end
                if (m_pixel_color !== want.color) begin
                    $error("pixel_color: expected %h, got %h", want.color, m_pixel_color);
                    fail_count++;
                end
                if (m_write_enable !== want.we) begin
                    $error("write_enable: expected %0b, got %0b", want.we, m_write_enable);
                    fail_count++;
                end
                if (m_last !== want.last) begin
                    $error("last: expected %0b, got %0b", want.last, m_last);
                    fail_count++;
                end
            end
        end
    end

    // receiver: random stall bursts plus the occasional long hold
    initial begin
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_req != 0) begin
                sink_stall_left = hold_req;
                hold_req = 0;
            end else if (sink_stall_left == 0 && sink_idle_en && $urandom_range(0, 7) == 0) begin
                sink_stall_left = $urandom_range(1, 17);
            end
            if (sink_stall_left != 0) begin
                m_ready <= 1'b0;
                sink_stall_left--;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $error("timeout after %0d cycles, %0d pixels outstanding", cycle_count,
               pending_pixels.size());
        $display("line_rasterizer_core verification failed");
        $finish;
    end

    // valid is left high on return so back-to-back beats never drop it
    task automatic send_beat(logic op, logic signed [CW-1:0] xs, logic signed [CW-1:0] ys,
                             logic signed [CW-1:0] xe, logic signed [CW-1:0] ye,
                             logic [COLOR_W-1:0] color);
        pixel_t px;
        if (src_idle_en && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_op <= op;
        s_x_start <= xs;
        s_y_start <= ys;
        s_x_end <= xe;
        s_y_end <= ye;
        s_line_color <= color;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        px = rasterize(op, xs, ys, xe, ye, color);
        pending_pixels.push_back(px);
        beats_sent++;
        if (op == OP_START) lines_started++;
    endtask

    // step beats carry junk in the unused fields
    task automatic send_step();
        send_beat(OP_STEP, CW'($urandom()), CW'($urandom()), CW'($urandom()),
                  CW'($urandom()), $urandom());
    endtask

    task automatic send_line(int xs, int ys, int xe, int ye, logic [COLOR_W-1:0] color,
                             int steps);
        send_beat(OP_START, xs[CW-1:0], ys[CW-1:0], xe[CW-1:0], ye[CW-1:0], color);
        repeat (steps) send_step();
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_pixels.size() != 0) @(posedge aclk);
    endtask

    task automatic set_surface(int w, int h);
        cfg_we <= 1'b1;
        cfg_index <= CFG_SURFACE_WIDTH;
        cfg_data <= w[CFG_DATA_W-1:0];
        @(posedge aclk);
        cfg_index <= CFG_SURFACE_HEIGHT;
        cfg_data <= h[CFG_DATA_W-1:0];
        @(posedge aclk);
        cfg_we <= 1'b0;
        surf_w = w[CFG_DATA_W-1:0];
        surf_h = h[CFG_DATA_W-1:0];
        settings_tried++;
    endtask

    task automatic send_random_line();
        logic signed [CW-1:0] xs, ys, xe, ye;
        int kind, span, steps;
        if (allow_idle && $urandom_range(0, 15) == 0) begin
            src_idle_en = $urandom_range(0, 1);
            sink_idle_en = $urandom_range(0, 1);
        end
        kind = $urandom_range(0, 19);
        if (kind == 16) begin
            // noise: random ops with random content
            repeat ($urandom_range(1, 4))
                send_beat($urandom_range(0, 1), CW'($urandom()), CW'($urandom()),
                          CW'($urandom()), CW'($urandom()), $urandom());
        end else begin
            if (kind < 14) begin
                xs = near_coord(int'(surf_w));
                ys = near_coord(int'(surf_h));
            end else begin
                xs = CW'($urandom());
                ys = CW'($urandom());
            end
            span = ($urandom_range(0, 9) == 0) ? 150 : 24;
            xe = offset_coord(xs, span);
            ye = offset_coord(ys, span);
            if (kind == 19) begin
                xe = CW'($urandom());
                ye = CW'($urandom());
            end
            send_beat(OP_START, xs, ys, xe, ye, $urandom());
            steps = pixels_left;
            // cut short: the next start drops the line
            if (kind >= 18) steps = $urandom_range(0, (steps < 8) ? steps : 8);
            else if (kind == 17) steps = steps + $urandom_range(1, 3);
            repeat (steps) send_step();
        end
    endtask

    task automatic run_traffic(int target);
        int first;
        first = beats_sent;
        while (beats_sent - first < target) send_random_line();
    endtask

    task automatic test_directed_lines();
        src_idle_en = 1'b1;
        sink_idle_en = 1'b1;
        send_step();                                        // step with no line active
        send_line(5, 5, 5, 5, 32'hffff_ffff, 1);            // single point, then idle step
        send_line(0, 0, 3, 0, 32'h1234_5678, 3);            // horizontal
        send_line(0, 0, -4, 2, 32'h8000_0001, 4);           // x-major, x decreasing
        send_line(3, 3, 3, 0, 32'h00ff_00ff, 3);            // vertical, endpoints swapped
        send_line(0, 0, 2, 5, 32'h0f0f_0f0f, 2);            // y-major, dropped by next start
        send_line(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, 32'hffff_ffff, 1);
        send_line(COORD_MAX, COORD_MAX, COORD_MIN, COORD_MAX, 32'h0000_0000, 1);
        send_line(COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN, 32'h5555_aaaa, 1);
    endtask

    // sender pauses for a full drain before each surface change
    task automatic test_surface_sweep();
        int w, h;
        for (int i = 0; i < 7; i++) begin
            wait_drained();
            case (i)
                0: begin w = 16; h = 12; end
                1: begin w = 1; h = 1; end
                2: begin w = 32767; h = 32767; end
                3: begin w = 0; h = 0; end           // nothing is inside
                4: begin w = 32767; h = 1; end
                default: begin
                    w = $urandom_range(1, 64);
                    h = $urandom_range(1, 64);
                end
            endcase
            set_surface(w, h);
            src_idle_en = 1'b1;
            sink_idle_en = 1'b1;
            run_traffic(180);
        end
    endtask

    // receiver holds off long enough for the queue to fill and stall s_ready
    task automatic test_output_stall();
        wait_drained();
        src_idle_en = 1'b0;
        hold_req = LONG_HOLD;
        send_line(2, 1, 14, 6, 32'hdead_beef, 12);
        send_line(7, 0, 4, 11, 32'hcafe_f00d, 11);
        send_line(-3, 2, 9, 2, 32'h0123_4567, 12);
    endtask

    task automatic test_full_rate();
        allow_idle = 1'b0;
        src_idle_en = 1'b0;
        sink_idle_en = 1'b0;
        run_traffic(300);
    endtask

    initial begin
        aresetn <= 1'b0;
        cfg_we <= 1'b0;
        cfg_index <= CFG_SURFACE_WIDTH;
        cfg_data <= '0;
        s_valid <= 1'b0;
        s_op <= OP_START;
        s_x_start <= '0;
        s_y_start <= '0;
        s_x_end <= '0;
        s_y_end <= '0;
        s_line_color <= '0;
        reset_model();
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        test_directed_lines();
        test_surface_sweep();
        test_output_stall();
        test_full_rate();
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge aclk);
        $display("%0d beats over %0d lines, %0d pixels checked, %0d surface settings",
                 beats_sent, lines_started, pixels_checked, settings_tried);
        if (fail_count == 0)
            $display("line_rasterizer_core verification clean");
        else
            $display("line_rasterizer_core verification failed");
        $finish;
    end

endmodule
